/* hw/rtl/swmv_pkg.sv */
// swmv_pkg: shared constants, codes and types for the majority vote block
// no dependencies
package swmv_pkg;

    localparam int MAX_LABELS_DEF   = 16;
    localparam int WINDOW_DEPTH_DEF = 32;

    localparam int LABEL_W      = 4;
    localparam int NUM_LABELS_W = 5;
    localparam int WIN_LEN_W    = 6;
    localparam int CFG_DATA_W   = 6;
    localparam int CFG_IDX_W    = 1;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_LABELS    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b1;

    localparam logic [NUM_LABELS_W-1:0] NUM_LABELS_RST    = 5'd16;
    localparam logic [WIN_LEN_W-1:0]    WINDOW_LENGTH_RST = 6'd32;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_OLD  = 7'b0000010,
        S_DEC  = 7'b0000100,
        S_INC  = 7'b0001000,
        S_SCAN = 7'b0010000,
        S_LAST = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    typedef struct packed {
        logic accept;
        logic rd_old;
        logic dec;
        logic inc;
        logic scan_rd;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } t_dp_stat;

endpackage

/* hw/rtl/swmv_in_if.sv */
// swmv_in_if: input channel carrying one label word
// depends on swmv_pkg
interface swmv_in_if import swmv_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [LABEL_W-1:0] label;

    modport source (output valid, output label, input ready);
    modport sink (input valid, input label, output ready);
endinterface

/* hw/rtl/swmv_out_if.sv */
// swmv_out_if: output channel carrying one winner word
// depends on swmv_pkg
interface swmv_out_if import swmv_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [LABEL_W-1:0] winner;

    modport source (output valid, output winner, input ready);
    modport sink (input valid, input winner, output ready);
endinterface

/* hw/rtl/sliding_window_majority_vote_top.sv */
// sliding_window_majority_vote_top: majority vote over the last labels of a stream
// one word at a time: a new word is taken only in idle, after the serial scan of the count ram and the result load
// reset: synchronous active low; counts, pointer and fill level cleared, no clearing pass
// depends on swmv_pkg, swmv_in_if, swmv_out_if, swmv_ctrl, swmv_dp
module sliding_window_majority_vote_top import swmv_pkg::*; #(
    parameter int MAX_LABELS   = MAX_LABELS_DEF,
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    swmv_in_if.sink               i_in,
    swmv_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    logic [NUM_LABELS_W-1:0] r_num_labels;
    logic [WIN_LEN_W-1:0]    r_window_length;
    logic                    clear;

    assign clear = i_cfg_we && (i_cfg_idx == REG_WINDOW_LENGTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_labels    <= NUM_LABELS_RST;
            r_window_length <= WINDOW_LENGTH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_NUM_LABELS:    r_num_labels    <= i_cfg_data[NUM_LABELS_W-1:0];
                REG_WINDOW_LENGTH: r_window_length <= i_cfg_data[WIN_LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    t_dp_cmd  cmd;
    t_dp_stat stat;

    swmv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    swmv_dp #(
        .MAX_LABELS   (MAX_LABELS),
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_clear         (clear),
        .i_num_labels    (r_num_labels),
        .i_window_length (r_window_length),
        .i_label         (i_in.label),
        .o_out_valid     (o_out.valid),
        .i_out_ready     (o_out.ready),
        .o_winner        (o_out.winner)
    );
endmodule

/* hw/rtl/swmv_ram.sv */
// swmv_ram: generic single write, single read ram with registered read
// read-first on a same-address write; no dependencies
module swmv_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* hw/rtl/swmv_ctrl.sv */
// swmv_ctrl: sequencer for ring update, count update and winner scan
// depends on swmv_pkg
module swmv_ctrl import swmv_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);
    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_OLD;
                end
            end
            S_OLD: begin
                o_cmd.rd_old = 1'b1;
                n_state      = S_DEC;
            end
            S_DEC: begin
                o_cmd.dec = 1'b1;
                n_state   = S_INC;
            end
            S_INC: begin
                o_cmd.inc = 1'b1;
                n_state   = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_OLD))
        else $error("accepted word did not start the update");

    a_load_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_stat.out_free)
        else $error("result loaded over a pending word");

    a_done_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && i_stat.out_free) |=> (r_state == S_IDLE))
        else $error("sequencer did not return to idle after result");
endmodule

/* hw/rtl/swmv_dp.sv */
// swmv_dp: label ring, vote counts, scan comparator and result register
// depends on swmv_pkg and swmv_ram
module swmv_dp import swmv_pkg::*; #(
    parameter int MAX_LABELS   = MAX_LABELS_DEF,
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    output t_dp_stat                o_stat,
    input  logic                    i_clear,
    input  logic [NUM_LABELS_W-1:0] i_num_labels,
    input  logic [WIN_LEN_W-1:0]    i_window_length,
    input  logic [LABEL_W-1:0]      i_label,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [LABEL_W-1:0]      o_winner
);
    localparam int LW = $clog2(MAX_LABELS);
    localparam int PW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CW = $clog2(WINDOW_DEPTH + 1);

    logic [CW-1:0] w_eff;
    logic [LW-1:0] nl_m1;
    int            nl_int;
    int            w_int;

    always_comb begin
        w_int = int'(i_window_length);
        if (w_int == 0) begin
            w_int = 1;
        end else if (w_int > WINDOW_DEPTH) begin
            w_int = WINDOW_DEPTH;
        end
        nl_int = int'(i_num_labels);
        if (nl_int == 0) begin
            nl_int = 1;
        end else if (nl_int > MAX_LABELS) begin
            nl_int = MAX_LABELS;
        end
        w_eff = CW'(w_int);
        nl_m1 = LW'(nl_int - 1);
    end

    // ring pointer and fill level
    logic [PW-1:0] r_wp;
    logic [CW-1:0] r_fill;
    logic [PW-1:0] wp_eff;
    logic [PW-1:0] wp_next;
    logic          evict;

    assign wp_eff  = (int'(r_wp) >= int'(w_eff)) ? '0 : r_wp;
    assign wp_next = (int'(wp_eff) + 1 >= int'(w_eff)) ? '0 : PW'(int'(wp_eff) + 1);
    assign evict   = (r_fill >= w_eff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_wp   <= '0;
            r_fill <= '0;
        end else if (i_cmd.accept) begin
            r_wp   <= wp_next;
            r_fill <= evict ? w_eff : CW'(int'(r_fill) + 1);
        end
    end

    logic [LABEL_W-1:0] ring_rdata;

    swmv_ram #(
        .WIDTH (LABEL_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept),
        .i_waddr (wp_eff),
        .i_wdata (i_label),
        .i_re    (i_cmd.accept),
        .i_raddr (wp_eff),
        .o_rdata (ring_rdata)
    );

    // label capture and count addressing
    logic [LABEL_W-1:0]    r_lab;
    logic                  r_evict;
    logic [LW+LABEL_W-1:0] lab_ext;
    logic [LW+LABEL_W-1:0] old_ext;
    logic [LW-1:0]         lab_addr;
    logic [LW-1:0]         old_addr;
    logic                  lab_ok;
    logic                  old_ok;

    assign lab_ext  = {LW'(0), r_lab};
    assign old_ext  = {LW'(0), ring_rdata};
    assign lab_addr = lab_ext[LW-1:0];
    assign old_addr = old_ext[LW-1:0];
    assign lab_ok   = (int'(r_lab) < MAX_LABELS);
    assign old_ok   = (int'(ring_rdata) < MAX_LABELS);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_lab   <= i_label;
            r_evict <= evict;
        end
    end

    // vote counts with per-entry valid bits, invalid reads as zero
    logic [MAX_LABELS-1:0] r_valid;
    logic                  r_rd_vld;
    logic [LW-1:0]         r_old_addr;
    logic                  r_dec_ok;
    logic                  r_hit;
    logic [LW-1:0]         r_idx;
    logic [CW-1:0]         cnt_rdata;
    logic [CW-1:0]         cnt_rd;
    logic                  cnt_we;
    logic [LW-1:0]         cnt_waddr;
    logic [CW-1:0]         cnt_wdata;
    logic                  cnt_re;
    logic [LW-1:0]         cnt_raddr;
    logic                  dec_wr;

    assign cnt_rd = r_rd_vld ? cnt_rdata : '0;
    assign dec_wr = i_cmd.dec && r_dec_ok && (cnt_rd != '0);

    always_comb begin
        cnt_we    = 1'b0;
        cnt_waddr = r_old_addr;
        cnt_wdata = CW'(int'(cnt_rd) - 1);
        cnt_re    = 1'b0;
        cnt_raddr = r_idx;
        if (i_cmd.rd_old) begin
            cnt_re    = 1'b1;
            cnt_raddr = old_addr;
        end
        if (i_cmd.dec) begin
            cnt_we    = dec_wr;
            cnt_re    = 1'b1;
            cnt_raddr = lab_addr;
        end
        if (i_cmd.inc) begin
            cnt_we    = lab_ok;
            cnt_waddr = lab_addr;
            // a same-cycle decrement of this label is not in the read data
            cnt_wdata = r_hit ? cnt_rd : CW'(int'(cnt_rd) + 1);
        end
        if (i_cmd.scan_rd) begin
            cnt_re    = 1'b1;
            cnt_raddr = r_idx;
        end
    end

    swmv_ram #(
        .WIDTH (CW),
        .DEPTH (MAX_LABELS)
    ) u_counts (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_re    (cnt_re),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid <= '0;
        end else if (cnt_we) begin
            r_valid[cnt_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cnt_re) begin
            r_rd_vld <= r_valid[cnt_raddr];
        end
        if (i_cmd.rd_old) begin
            r_old_addr <= old_addr;
            r_dec_ok   <= r_evict && old_ok;
        end
        if (i_cmd.dec) begin
            r_hit <= dec_wr && (r_old_addr == lab_addr);
        end
    end

    // winner scan
    logic                  r_cmp_en;
    logic [LW-1:0]         r_cmp_idx;
    logic [CW-1:0]         r_best;
    logic [LW-1:0]         r_best_idx;
    logic [LW+LABEL_W-1:0] best_ext;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_idx <= '0;
        end else if (i_cmd.scan_rd) begin
            r_idx <= LW'(int'(r_idx) + 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_en <= 1'b0;
        end else begin
            r_cmp_en <= i_cmd.scan_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_rd) begin
            r_cmp_idx <= r_idx;
        end
        if (r_cmp_en && (r_cmp_idx == '0 || cnt_rd > r_best)) begin
            r_best     <= cnt_rd;
            r_best_idx <= r_cmp_idx;
        end
    end

    assign o_stat.scan_last = (r_idx == nl_m1);

    // result register
    logic               r_out_valid;
    logic [LABEL_W-1:0] r_winner;

    assign best_ext = {LABEL_W'(0), r_best_idx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_winner <= best_ext[LABEL_W-1:0];
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_winner        = r_winner;

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= w_eff)
        else $error("fill level beyond window length");

    a_hit_needs_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.dec && !dec_wr) |=> !r_hit)
        else $error("count bypass without a decrement");
endmodule

/* tb/tb_sliding_window_majority_vote_top.sv */
`timescale 1ns / 1ps
// tb_sliding_window_majority_vote_top: self-checking bench for the majority vote block
// a scoreboard class predicts the winner of every accepted label word, tasks drive the ports
// depends on swmv_pkg, swmv_in_if, swmv_out_if and sliding_window_majority_vote_top
module tb_sliding_window_majority_vote_top;
    import swmv_pkg::*;

    localparam int MAX_LABELS   = MAX_LABELS_DEF;
    localparam int WINDOW_DEPTH = WINDOW_DEPTH_DEF;
    localparam int SETTLE       = 40;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int PHASES       = 13;
    localparam int PHASE_ITEMS  = 100;

    class vote_scoreboard;
        logic [LABEL_W-1:0]      ring [WINDOW_DEPTH];
        int unsigned             counts [MAX_LABELS];
        int unsigned             wr_ptr;
        int unsigned             fill;
        logic [NUM_LABELS_W-1:0] nl_reg;
        logic [WIN_LEN_W-1:0]    wl_reg;
        logic [LABEL_W-1:0]      expected_winners [$];
        int                      mismatches;
        int                      labels_seen;
        int                      winners_checked;
        int                      reg_writes;

        function new();
            nl_reg = NUM_LABELS_RST;
            wl_reg = WINDOW_LENGTH_RST;
            mismatches = 0;
            labels_seen = 0;
            winners_checked = 0;
            reg_writes = 0;
            clear_window();
        endfunction

        function void clear_window();
            for (int i = 0; i < WINDOW_DEPTH; i++) ring[i] = '0;
            for (int i = 0; i < MAX_LABELS; i++) counts[i] = 0;
            wr_ptr = 0;
            fill = 0;
        endfunction

        function int unsigned sat_to(int unsigned v, int unsigned hi);
            if (v == 0) return 1;
            if (v > hi) return hi;
            return v;
        endfunction

        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            reg_writes++;
            if (idx == REG_NUM_LABELS) begin
                nl_reg = data[NUM_LABELS_W-1:0];
            end else if (idx == REG_WINDOW_LENGTH) begin
                wl_reg = data[WIN_LEN_W-1:0];
                clear_window();
            end
        endfunction

        function void note_label(logic [LABEL_W-1:0] lab);
            int unsigned w;
            int unsigned nl;
            int unsigned wp;
            int unsigned best;
            int unsigned best_idx;
            logic [LABEL_W-1:0] oldest;
            w = sat_to(32'(wl_reg), WINDOW_DEPTH);
            nl = sat_to(32'(nl_reg), MAX_LABELS);
            wp = wr_ptr;
            labels_seen++;
            if (wp >= w) wp = 0;
            if (fill >= w) begin
                oldest = ring[wp];
                if (oldest < MAX_LABELS && counts[oldest] > 0) counts[oldest]--;
                fill = w;
            end else begin
                fill++;
            end
            ring[wp] = lab;
            if (lab < MAX_LABELS) counts[lab]++;
            wp++;
            if (wp >= w) wp = 0;
            wr_ptr = wp;
            best = counts[0];
            best_idx = 0;
            for (int i = 1; i < nl; i++) begin
                if (counts[i] > best) begin
                    best = counts[i];
                    best_idx = i;
                end
            end
            expected_winners.push_back(best_idx[LABEL_W-1:0]);
        endfunction

        function void check_winner(logic [LABEL_W-1:0] got);
            logic [LABEL_W-1:0] want;
            winners_checked++;
            if (expected_winners.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("winner %0d arrived with none expected", got);
            end else begin
                want = expected_winners.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("winner mismatch: expected %0d, actual %0d", want, got);
                end
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    bit                    no_idle;
    logic [LABEL_W-1:0]    run_label;
    int unsigned           cycles;
    vote_scoreboard        sb;

    swmv_in_if  in_if ();
    swmv_out_if out_if ();

    sliding_window_majority_vote_top #(
        .MAX_LABELS   (MAX_LABELS),
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        sb = new();
    end

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
    end

    // observe accepted words, register writes and delivered winners
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) sb.apply_reg(i_cfg_idx, i_cfg_data);
            if (in_if.valid && in_if.ready) sb.note_label(in_if.label);
            if (out_if.valid && out_if.ready) sb.check_winner(out_if.winner);
        end
    end

    function automatic int unsigned draw_gap();
        if (no_idle) return 0;
        return $urandom_range(0, 14);
    endfunction

    function logic [LABEL_W-1:0] draw_label(int unsigned mode);
        case (mode)
            0: return LABEL_W'($urandom_range(0, 15));
            1: begin
                if ($urandom_range(0, 3) == 0) return LABEL_W'($urandom_range(0, 15));
                return LABEL_W'($urandom_range(0, 3));
            end
            default: begin
                // runs of one label
                if ($urandom_range(0, 3) == 0) run_label = LABEL_W'($urandom_range(0, 15));
                return run_label;
            end
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_num_labels();
        case ($urandom_range(0, 5))
            0: return 6'd16;
            1: return 6'd1;
            2: return 6'd0;
            3: return CFG_DATA_W'($urandom_range(0, 63));
            default: return CFG_DATA_W'($urandom_range(2, 16));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_window_length();
        case ($urandom_range(0, 5))
            0: return 6'd32;
            1: return 6'd1;
            2: return CFG_DATA_W'($urandom_range(0, 63));
            default: return CFG_DATA_W'($urandom_range(2, 12));
        endcase
    endfunction

    task automatic send_label(input logic [LABEL_W-1:0] lab);
        int unsigned gap;
        gap = draw_gap();
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.label <= lab;
        do @(posedge i_clk); while (!(in_if.valid && in_if.ready));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_winners.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // result side: random stalls, counted from when a winner shows up
    initial begin
        int unsigned gap;
        out_if.ready = 1'b0;
        forever begin
            gap = draw_gap();
            if (gap != 0) begin
                out_if.ready <= 1'b0;
                do @(posedge i_clk); while (!out_if.valid);
                repeat (gap - 1) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_if.valid && out_if.ready));
        end
    end

    initial begin
        int unsigned mode;
        int unsigned settings;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = REG_NUM_LABELS;
        i_cfg_data  = '0;
        in_if.valid = 1'b0;
        in_if.label = '0;
        no_idle     = 1'b0;
        run_label   = '0;
        cycles      = 0;
        settings    = 1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, extremes and ties
        send_label(4'd15);
        send_label(4'd0);
        send_label(4'd15);
        send_label(4'd0);
        send_label(4'd7);
        send_label(4'd8);
        send_label(4'd15);
        send_label(4'd15);

        // short window rewrite empties it, then eviction
        drain();
        write_reg(REG_WINDOW_LENGTH, 6'd3);
        settings++;
        send_label(4'd5);
        send_label(4'd5);
        send_label(4'd2);
        send_label(4'd2);
        send_label(4'd2);
        send_label(4'd9);

        // zero classes counts as one, counts kept
        drain();
        write_reg(REG_NUM_LABELS, 6'd0);
        settings++;
        send_label(4'd9);
        send_label(4'd3);

        // classes above limit, zero window length
        drain();
        write_reg(REG_NUM_LABELS, 6'd31);
        write_reg(REG_WINDOW_LENGTH, 6'd0);
        settings++;
        send_label(4'd4);
        send_label(4'd15);
        send_label(4'd0);

        // window and classes above limit
        drain();
        write_reg(REG_WINDOW_LENGTH, 6'd63);
        write_reg(REG_NUM_LABELS, 6'd17);
        settings++;
        send_label(4'd1);
        send_label(4'd2);
        send_label(4'd3);

        for (int p = 0; p < PHASES; p++) begin
            drain();
            no_idle = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 3))
                0: begin
                    write_reg(REG_NUM_LABELS, pick_num_labels());
                    write_reg(REG_WINDOW_LENGTH, pick_window_length());
                    settings++;
                end
                1: begin
                    write_reg(REG_NUM_LABELS, pick_num_labels());
                    settings++;
                end
                2: begin
                    write_reg(REG_WINDOW_LENGTH, pick_window_length());
                    settings++;
                end
                default: ;
            endcase
            mode = $urandom_range(0, 2);
            for (int n = 0; n < PHASE_ITEMS; n++) send_label(draw_label(mode));
        end

        drain();
        $display("sent %0d labels and checked %0d winners", sb.labels_seen, sb.winners_checked);
        $display("%0d register writes across %0d settings, %0d mismatches",
                 sb.reg_writes, settings, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_winners.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
